// ===== hw/rtl/swr_pkg.sv =====
// Shared constants and types for the sliding window range block.
`timescale 1ns / 1ps
package swr_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int WL_W       = 6;
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 17;
  localparam int WL_RESET   = 8;

  typedef struct packed {
    logic valid;
    logic first;
  } mm_ctl_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_EMIT   = 6'b000100,
    ST_WRITE  = 6'b001000,
    ST_FL_RD  = 6'b010000,
    ST_FL_OUT = 6'b100000
  } state_t;

endpackage

// ===== hw/rtl/swr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module swr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/swr_minmax.sv =====
// Running maximum and minimum over the words read back from the ring.
`timescale 1ns / 1ps
module swr_minmax (
  input  logic                                 clk,
  input  swr_pkg::mm_ctl_t                     ctl,
  input  logic signed [swr_pkg::SAMPLE_W-1:0]  din,
  output logic        [swr_pkg::VALUE_W-1:0]   range
);
  import swr_pkg::*;

  logic signed [SAMPLE_W-1:0] mx_r, mx_nxt;
  logic signed [SAMPLE_W-1:0] mn_r, mn_nxt;

  always_comb begin
    mx_nxt = mx_r;
    mn_nxt = mn_r;
    if (ctl.valid) begin
      if (ctl.first) begin
        mx_nxt = din;
        mn_nxt = din;
      end else begin
        if (din > mx_r) mx_nxt = din;
        if (din < mn_r) mn_nxt = din;
      end
    end
  end

  always_ff @(posedge clk) begin
    mx_r <= mx_nxt;
    mn_r <= mn_nxt;
  end

  assign range = {mx_r[SAMPLE_W-1], mx_r} - {mn_r[SAMPLE_W-1], mn_r};

endmodule

// ===== hw/rtl/sliding_window_range.sv =====
// Top level: sliding window max-minus-min with raw tail flush.
//
//  channel  | handshake              | tdata                         | tlast           | tuser
//  ---------+------------------------+-------------------------------+-----------------+-------
//  in_      | in_tvalid / in_tready  | [15:0] sample                 | is_last         | -
//  out_     | out_tvalid / out_tready| [16:0] value, [23:17] zero    | end_of_sequence | is_raw
//  cfg_     | cfg_wr_en              | cfg_wr_data[5:0] window_length| -               | -
//
// Order: a range that is due is scanned first (one ring read per window sample
// through the single read port), then the item is written; raw tail samples follow.
// The ring memory has one read and one write port; the scan is the long pole.
// Reset clears control state only; ring contents are undefined until written.
// Output stalls hold the result register; the next item is taken while a
// result still waits for the consumer.
`timescale 1ns / 1ps
module sliding_window_range (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] sample
  input  logic        in_tlast,     // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,    // [16:0] value, [23:17] zero
  output logic        out_tlast,    // end_of_sequence
  output logic        out_tuser,    // is_raw
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data   // window_length
);
  import swr_pkg::*;

  state_t state_r, state_nxt;

  logic [WL_W-1:0]     wl_r, wl_nxt;
  logic [SLOT_W-1:0]   wp_r, wp_nxt;
  logic [CNT_W-1:0]    held_r, held_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                last_r, last_nxt;
  logic                rv_r, rv_nxt;
  logic                rfirst_r, rfirst_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_raw_r, out_raw_nxt;
  logic                out_eos_r, out_eos_nxt;

  logic [CNT_W-1:0]    w_eff;
  logic                out_free;
  logic [SLOT_W-1:0]   base;
  logic                ram_we;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [VALUE_W-1:0]  range;
  mm_ctl_t             mm_ctl;

  always_comb begin
    if (wl_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (CNT_W'(wl_r) > CNT_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(wl_r);
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign base      = wp_r - held_r[SLOT_W-1:0];
  assign ram_raddr = base + cnt_r[SLOT_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign mm_ctl    = '{valid: rv_r, first: rfirst_r};

  always_comb begin
    state_nxt     = state_r;
    wl_nxt        = wl_r;
    wp_nxt        = wp_r;
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    rv_nxt        = 1'b0;
    rfirst_nxt    = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_value_nxt = out_value_r;
    out_raw_nxt   = out_raw_r;
    out_eos_nxt   = out_eos_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata;
          last_nxt   = in_tlast;
          cnt_nxt    = '0;
          state_nxt  = (held_r >= w_eff) ? ST_SCAN : ST_WRITE;
        end
      end
      ST_SCAN: begin
        if (cnt_r < w_eff) begin
          ram_re     = 1'b1;
          rv_nxt     = 1'b1;
          rfirst_nxt = (cnt_r == '0);
          cnt_nxt    = cnt_r + 1'b1;
        end else if (!rv_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = range;
          out_raw_nxt   = 1'b0;
          out_eos_nxt   = 1'b0;
          held_nxt      = w_eff - 1'b1;
          state_nxt     = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ram_we   = 1'b1;
        wp_nxt   = wp_r + 1'b1;
        held_nxt = held_r + 1'b1;
        cnt_nxt  = '0;
        state_nxt = last_r ? ST_FL_RD : ST_IDLE;
      end
      ST_FL_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_FL_OUT;
      end
      ST_FL_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = {ram_rdata[SAMPLE_W-1], ram_rdata};
          out_raw_nxt   = 1'b1;
          out_eos_nxt   = (cnt_r + 1'b1 == held_r);
          if (cnt_r + 1'b1 == held_r) begin
            held_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      wl_nxt   = cfg_wr_data;
      held_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= WL_W'(WL_RESET);
      wp_r        <= '0;
      held_r      <= '0;
      cnt_r       <= '0;
      rv_r        <= 1'b0;
      rfirst_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wl_r        <= wl_nxt;
      wp_r        <= wp_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      rv_r        <= rv_nxt;
      rfirst_r    <= rfirst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r    <= sample_nxt;
    last_r      <= last_nxt;
    out_value_r <= out_value_nxt;
    out_raw_r   <= out_raw_nxt;
    out_eos_r   <= out_eos_nxt;
  end

  swr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (sample_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swr_minmax u_minmax (
    .clk   (clk),
    .ctl   (mm_ctl),
    .din   (ram_rdata),
    .range (range)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_value_r};
  assign out_tlast  = out_eos_r;
  assign out_tuser  = out_raw_r;

endmodule

// ===== hw/rtl/swr_checker.sv =====
// Port-level assertions for the sliding window range block, with bind.
`timescale 1ns / 1ps
module swr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction dropped or changed while stalled");

  a_eos_raw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("end of sequence on a range result");

  a_range_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> !out_tdata[16])
    else $error("negative window range");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while one is in work");

endmodule

bind sliding_window_range swr_checker u_swr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
